>>> hdl/frame_sequence_animator_defines.svh
// Assertion macros for the frame sequence animator.
// Needs a clock named clk and an active-low reset named arst_n in the using module.
`ifndef FRAME_SEQUENCE_ANIMATOR_DEFINES_SVH
`define FRAME_SEQUENCE_ANIMATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/fsa_pkg.sv
// Shared types and constants for the frame sequence animator.
// No dependencies.
package fsa_pkg;

	localparam int MAX_FRAMES = 64;
	localparam int FRAC_BITS  = 8;
	localparam int DUR_W      = 16;
	localparam int TIME_W     = DUR_W + FRAC_BITS;
	localparam int POS_W      = 6;
	localparam int COUNT_W    = 7;
	localparam int SPEED_W    = 12;
	localparam int PLAYS_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [SPEED_W-1:0] SPEED_MIN   = SPEED_W'(3);
	localparam logic [SPEED_W-1:0] SPEED_MAX   = SPEED_W'(2560);
	localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(256);
	localparam logic [PLAYS_W-1:0] PLAYS_MAX   = '1;

	// Playback modes; the fourth code plays forward.
	localparam logic [1:0] MODE_FWD  = 2'd0;
	localparam logic [1:0] MODE_REV  = 2'd1;
	localparam logic [1:0] MODE_PING = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAY_COUNT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN         = 3'd5;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_WRITE   = 2'd1,
		OP_RESTART = 2'd2,
		OP_FORCE   = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [POS_W-1:0] index;
		logic [DUR_W-1:0] duration;
	} in_word_t;

	typedef struct packed {
		logic [POS_W-1:0]  frame;
		logic [TIME_W-1:0] elapsed;
		logic              done_res;
		logic              going_forward;
	} out_word_t;

endpackage

>>> hdl/frame_sequence_animator.sv
// Frame sequence animator: duration memory plus playback state update.
// Flow: an accepted word reads the duration memory into stage 1, then the
// state update fires and its result is registered as the output word; a new
// word is accepted only after the previous one has left stage 1.
// Reset: playback state and registers clear at once; duration memory is
// not cleared and holds garbage until each entry is written.
module frame_sequence_animator
	import fsa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_word_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	`include "frame_sequence_animator_defines.svh"

	// Configuration registers
	logic [1:0]         mode_q;
	logic               loop_q;
	logic [PLAYS_W-1:0] play_count_q;
	logic [SPEED_W-1:0] speed_q;
	logic [COUNT_W-1:0] frame_count_q;
	logic               run_q;

	// Playback state
	logic [POS_W-1:0]   frame_pos_q;
	logic [TIME_W-1:0]  time_acc_q;
	logic               finished_q;
	logic [PLAYS_W-1:0] plays_q;
	logic               forward_q;
	logic               pending_q;

	// Duration table: one write port, two registered read ports
	logic [DUR_W-1:0]   dur_mem [MAX_FRAMES];
	logic [DUR_W-1:0]   rd_a_s1;
	logic [DUR_W-1:0]   rd_b_s1;
	in_word_t           item_s1;
	logic               item_valid_s1;

	out_word_t          out_q;
	logic               out_valid_q;

	logic               accept;
	logic               eval_fire;

	// Derived values from state and config
	logic [COUNT_W-1:0] n_eff;
	logic [POS_W-1:0]   last_pos;
	logic [POS_W-1:0]   clamp_pos;
	logic [POS_W-1:0]   start_pos;
	logic [POS_W-1:0]   addr_b;
	logic [SPEED_W-1:0] spd_eff;
	logic [PLAYS_W-1:0] pc_eff;
	logic [TIME_W-1:0]  dur_a;
	logic [TIME_W-1:0]  dur_b;
	logic               tick_runs;

	// Next-state values
	logic [POS_W-1:0]   nx_pos;
	logic [TIME_W-1:0]  nx_time;
	logic               nx_fin;
	logic [PLAYS_W-1:0] nx_plays;
	logic               nx_fwd;
	logic               nx_pend;
	logic               backward;
	logic               bounce;
	logic               end_hit;
	logic [TIME_W-1:0]  end_time;
	logic [TIME_W:0]    t_sum;
	logic [PLAYS_W-1:0] plays_inc;

	assign accept    = in_valid && in_ready;
	// One word in flight; the output register lets the next word in while a
	// result still waits.
	assign in_ready  = !item_valid_s1;
	assign eval_fire = item_valid_s1 && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Frame count clamp and last frame
	assign n_eff     = (frame_count_q > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES)
	                                                          : frame_count_q;
	assign last_pos  = (n_eff == '0) ? '0 : POS_W'(n_eff - COUNT_W'(1));
	assign clamp_pos = ({1'b0, frame_pos_q} >= n_eff) ? last_pos : frame_pos_q;

	// Frame the tick starts from, after a pending restart is carried out.
	// State moves between accept and update only through a config write; without
	// one, the same value serves as read address and in the update.
	assign start_pos = pending_q ? ((mode_q == MODE_REV) ? last_pos : '0) : clamp_pos;
	// Second read: the frame before, or the last frame when the tick starts from frame 0.
	assign addr_b    = (start_pos != '0) ? (start_pos - POS_W'(1)) : last_pos;

	assign spd_eff   = (speed_q < SPEED_MIN) ? SPEED_MIN :
	                   (speed_q > SPEED_MAX) ? SPEED_MAX : speed_q;
	assign pc_eff    = (play_count_q == '0) ? PLAYS_W'(1) : play_count_q;
	assign dur_a     = {rd_a_s1, FRAC_BITS'(0)};
	assign dur_b     = {rd_b_s1, FRAC_BITS'(0)};
	assign tick_runs = run_q && !finished_q && (n_eff != '0);

	always_ff @(posedge clk) begin
		if (accept) begin
			if (in_data.op == OP_WRITE) begin
				dur_mem[in_data.index] <= in_data.duration;
			end
			rd_a_s1 <= dur_mem[start_pos];
			rd_b_s1 <= dur_mem[addr_b];
			item_s1 <= in_data;
		end
	end

	// Update logic for the word in stage 1
	always_comb begin
		nx_pos    = frame_pos_q;
		nx_time   = time_acc_q;
		nx_fin    = finished_q;
		nx_plays  = plays_q;
		nx_fwd    = forward_q;
		nx_pend   = pending_q;
		backward  = 1'b0;
		bounce    = 1'b0;
		end_hit   = 1'b0;
		end_time  = '0;
		t_sum     = '0;
		plays_inc = plays_q;
		unique case (item_s1.op)
			OP_TICK: begin
				if (tick_runs) begin
					nx_pos  = start_pos;
					nx_time = pending_q ? ((mode_q == MODE_REV) ? dur_a : '0) : time_acc_q;
					nx_fwd  = pending_q ? 1'b1 : forward_q;
					nx_pend = 1'b0;
					bounce   = (mode_q == MODE_PING) && (n_eff > COUNT_W'(1));
					backward = (mode_q == MODE_REV) || (bounce && !nx_fwd);
					t_sum    = {1'b0, nx_time} + (TIME_W+1)'(spd_eff);
					if (backward) begin
						if (nx_time > TIME_W'(spd_eff)) begin
							nx_time = nx_time - TIME_W'(spd_eff);
						end else if (nx_pos != '0) begin
							nx_pos  = nx_pos - POS_W'(1);
							nx_time = dur_b;
						end else begin
							end_hit  = 1'b1;
							end_time = '0;
						end
					end else begin
						if (t_sum < {1'b0, dur_a}) begin
							nx_time = t_sum[TIME_W-1:0];
						end else if (({1'b0, nx_pos} + COUNT_W'(1)) < n_eff) begin
							nx_pos  = nx_pos + POS_W'(1);
							nx_time = '0;
						end else if (bounce) begin
							nx_fwd  = 1'b0;
							nx_time = dur_a;
						end else begin
							end_hit  = 1'b1;
							end_time = dur_a;
						end
					end
					if (end_hit) begin
						plays_inc = (plays_q == PLAYS_MAX) ? PLAYS_MAX : plays_q + PLAYS_W'(1);
						if (!loop_q) begin
							nx_plays = plays_inc;
						end
						if (loop_q || plays_inc < pc_eff) begin
							// restart in the same tick; reverse start reads
							// the last frame through port b
							nx_fin  = 1'b0;
							nx_pend = 1'b0;
							nx_fwd  = 1'b1;
							nx_pos  = (mode_q == MODE_REV) ? last_pos : '0;
							nx_time = (mode_q == MODE_REV) ? dur_b : '0;
						end else begin
							nx_time = end_time;
							nx_fin  = 1'b1;
						end
					end
				end
			end
			OP_WRITE: begin
			end
			OP_RESTART: begin
				nx_fin   = 1'b0;
				nx_plays = '0;
				nx_pend  = 1'b1;
				nx_fwd   = 1'b1;
			end
			OP_FORCE: begin
				nx_pos  = (item_s1.index > last_pos) ? last_pos : item_s1.index;
				nx_time = '0;
				nx_fin  = 1'b0;
				nx_pend = 1'b0;
				nx_fwd  = (mode_q != MODE_REV);
			end
		endcase
	end

	// Configuration registers; to be written only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_FWD;
			loop_q        <= 1'b0;
			play_count_q  <= PLAYS_W'(1);
			speed_q       <= SPEED_RESET;
			frame_count_q <= '0;
			run_q         <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:        mode_q        <= cfg_data[1:0];
				CFG_LOOP:        loop_q        <= cfg_data[0];
				CFG_PLAY_COUNT:  play_count_q  <= cfg_data[PLAYS_W-1:0];
				CFG_SPEED:       speed_q       <= cfg_data[SPEED_W-1:0];
				CFG_FRAME_COUNT: frame_count_q <= cfg_data[COUNT_W-1:0];
				CFG_RUN:         run_q         <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Playback state: updated by the stage-1 word or by a config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos_q <= '0;
			time_acc_q  <= '0;
			finished_q  <= 1'b0;
			plays_q     <= '0;
			forward_q   <= 1'b1;
			pending_q   <= 1'b1;
		end else if (eval_fire) begin
			frame_pos_q <= nx_pos;
			time_acc_q  <= nx_time;
			finished_q  <= nx_fin;
			plays_q     <= nx_plays;
			forward_q   <= nx_fwd;
			pending_q   <= nx_pend;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE, CFG_PLAY_COUNT: begin
					finished_q <= 1'b0;
					plays_q    <= '0;
					forward_q  <= 1'b1;
					pending_q  <= 1'b1;
				end
				CFG_FRAME_COUNT: begin
					if (cfg_data[COUNT_W-1:0] != frame_count_q) begin
						frame_pos_q <= '0;
						time_acc_q  <= '0;
						finished_q  <= 1'b0;
						plays_q     <= '0;
						forward_q   <= 1'b1;
						pending_q   <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Stage-1 valid and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				item_valid_s1 <= 1'b1;
			end else if (eval_fire) begin
				item_valid_s1 <= 1'b0;
			end
			if (eval_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eval_fire) begin
			out_q.frame         <= nx_pos;
			out_q.elapsed       <= nx_time;
			out_q.done_res      <= nx_fin;
			out_q.going_forward <= nx_fwd;
		end
	end

	// A running tick always lands on a frame inside the sequence.
	`FSA_ASSERT_NEXT(a_pos_in_range, eval_fire && item_s1.op == OP_TICK && tick_runs, {1'b0, frame_pos_q} < n_eff, "frame position beyond frame count after tick")
	// A running tick consumes any pending restart.
	`FSA_ASSERT_NEXT(a_pending_used, eval_fire && item_s1.op == OP_TICK && tick_runs, !pending_q, "restart still pending after running tick")
	// Forced frame starts at time zero, not finished.
	`FSA_ASSERT_NEXT(a_force_clears, eval_fire && item_s1.op == OP_FORCE, !finished_q && time_acc_q == '0, "forced frame left time or finished set")
	// Finished is reached only after the restart was carried out.
	`FSA_ASSERT_NOW(a_fin_no_pending, finished_q, !pending_q, "finished with restart pending")
	// Every update produces a result word.
	`FSA_ASSERT_NEXT(a_result_out, eval_fire, out_valid_q, "update without result word")

endmodule
